[hw/rtl/acs_pkg.sv]
// Shared types and constants for the alternating coordinate search block.
`timescale 1ns / 1ps

package acs_pkg;

    localparam int unsigned MAX_COORDS = 16;
    localparam int unsigned COORD_BITS = $clog2(MAX_COORDS);
    localparam int unsigned COUNT_BITS = COORD_BITS + 1;
    localparam int unsigned INDEX_BITS = 8;
    localparam int unsigned METRIC_BITS = 32;

    // Command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PROPOSE = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;

    // Stored search direction
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_STAY  = 2'd1,
        DIR_LEFT  = 2'd2
    } acs_dir_t;

    typedef struct packed {
        logic [1:0]                    cmd;
        logic [COORD_BITS-1:0]         coord_sel;
        logic [INDEX_BITS-1:0]         start_index;
        logic [INDEX_BITS-1:0]         last_index;
        logic                          trial_good;
        logic signed [METRIC_BITS-1:0] metric_before;
        logic signed [METRIC_BITS-1:0] metric_after;
    } acs_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] coord_out;
        logic [INDEX_BITS-1:0] value_index;
        logic                  updated;
        logic [1:0]            direction_out;
    } acs_out_t;

    // Table and pointer updates produced by one beat
    typedef struct packed {
        logic                  tbl_wr;
        logic [COORD_BITS-1:0] tbl_addr;
        logic                  idx_wr;
        logic [INDEX_BITS-1:0] idx_data;
        acs_dir_t              dir_data;
        logic                  ptr_wr;
        logic [COORD_BITS-1:0] ptr_data;
    } acs_upd_t;

endpackage

[hw/rtl/acs_step.sv]
// Combinational step logic: proposal, bounce, report decision and pointer advance.
`timescale 1ns / 1ps

module acs_step (
    input  acs_pkg::acs_in_t                  item,
    input  logic                              item_valid,
    input  logic [acs_pkg::INDEX_BITS-1:0]    cur_idx,
    input  acs_pkg::acs_dir_t                 cur_dir,
    input  logic [acs_pkg::COORD_BITS-1:0]    coord_ptr,
    input  logic [acs_pkg::COUNT_BITS-1:0]    coord_count,
    output acs_pkg::acs_out_t                 result,
    output acs_pkg::acs_upd_t                 upd
);
    import acs_pkg::*;

    logic [INDEX_BITS-1:0] clamp_idx;
    logic [INDEX_BITS-1:0] prop_idx;
    acs_dir_t              prop_dir;
    logic                  short_list;
    logic                  better;
    logic                  accept;
    acs_dir_t              adv_dir;
    acs_dir_t              rep_dir;
    logic [INDEX_BITS-1:0] rep_idx;
    logic [COUNT_BITS-1:0] active_cnt;
    logic [COUNT_BITS-1:0] ptr_inc;

    // Proposed step with bounce at either end of the list
    always_comb
    begin
        short_list = (item.last_index < INDEX_BITS'(2));
        clamp_idx  = (cur_idx > item.last_index) ? item.last_index : cur_idx;
        prop_idx   = clamp_idx;
        prop_dir   = cur_dir;
        if (short_list)
        begin
            prop_idx = cur_idx;
        end
        else
        begin
            case (cur_dir)
                DIR_RIGHT:
                begin
                    if (clamp_idx == item.last_index)
                    begin
                        prop_dir = DIR_LEFT;
                        prop_idx = clamp_idx - INDEX_BITS'(1);
                    end
                    else
                    begin
                        prop_idx = clamp_idx + INDEX_BITS'(1);
                    end
                end
                DIR_LEFT:
                begin
                    if (clamp_idx == '0)
                    begin
                        prop_dir = DIR_RIGHT;
                        prop_idx = clamp_idx + INDEX_BITS'(1);
                    end
                    else
                    begin
                        prop_idx = clamp_idx - INDEX_BITS'(1);
                    end
                end
                default:
                begin
                    prop_idx = clamp_idx;
                end
            endcase
        end
    end

    // Report decision: accept a good trial that gains or starts from stay, then advance direction if no gain
    always_comb
    begin
        better = item.metric_before[METRIC_BITS-1]
                 || (item.metric_after < item.metric_before);
        accept = item.trial_good && (better || (cur_dir == DIR_STAY));
        rep_idx = accept ? prop_idx : cur_idx;
        rep_dir = accept ? prop_dir : cur_dir;
        case (rep_dir)
            DIR_RIGHT: adv_dir = DIR_STAY;
            DIR_STAY:  adv_dir = DIR_LEFT;
            default:   adv_dir = DIR_RIGHT;
        endcase
        if (!better)
        begin
            rep_dir = adv_dir;
        end
    end

    // Round-robin pointer; out-of-range counts saturate
    always_comb
    begin
        if (coord_count == '0)
        begin
            active_cnt = COUNT_BITS'(1);
        end
        else if (coord_count > COUNT_BITS'(MAX_COORDS))
        begin
            active_cnt = COUNT_BITS'(MAX_COORDS);
        end
        else
        begin
            active_cnt = coord_count;
        end
        ptr_inc = {1'b0, coord_ptr} + COUNT_BITS'(1);
    end

    // Result and table updates per command
    always_comb
    begin
        result.coord_out     = coord_ptr;
        result.value_index   = cur_idx;
        result.updated       = 1'b0;
        result.direction_out = cur_dir;
        upd.tbl_wr   = 1'b0;
        upd.tbl_addr = coord_ptr;
        upd.idx_wr   = 1'b0;
        upd.idx_data = rep_idx;
        upd.dir_data = rep_dir;
        upd.ptr_wr   = 1'b0;
        upd.ptr_data = (ptr_inc >= active_cnt) ? '0 : ptr_inc[COORD_BITS-1:0];
        case (item.cmd)
            CMD_LOAD:
            begin
                result.coord_out     = item.coord_sel;
                result.value_index   = item.start_index;
                result.direction_out = DIR_RIGHT;
                upd.tbl_wr   = item_valid;
                upd.tbl_addr = item.coord_sel;
                upd.idx_wr   = item_valid;
                upd.idx_data = item.start_index;
                upd.dir_data = DIR_RIGHT;
            end
            CMD_PROPOSE:
            begin
                result.value_index   = prop_idx;
                result.direction_out = prop_dir;
                upd.tbl_wr   = item_valid;
                upd.dir_data = prop_dir;
            end
            CMD_REPORT:
            begin
                result.value_index   = rep_idx;
                result.updated       = accept;
                result.direction_out = rep_dir;
                upd.tbl_wr   = item_valid;
                upd.idx_wr   = item_valid;
                upd.ptr_wr   = item_valid;
            end
            default:
            begin
                result.value_index = cur_idx;
            end
        endcase
    end

endmodule

[hw/rtl/alternating_coordinate_search.sv]
// Top level of the alternating coordinate search: input register, state tables, result register.
//
//   channel  | signals                       | dir | beat
//   ---------+-------------------------------+-----+--------------------------
//   in       | in_valid/in_ready/in_data     | in  | one command
//   out      | out_valid/out_ready/out_data  | out | one result per command
//   cfg      | cfg_valid/cfg_ready/cfg_data  | in  | coord_count write
//
// One beat per cycle sustained while out_ready is high. An accepted beat is
// held in the input register, then passes through the step logic and the
// table read/write into the result register, which raises out_valid. Each
// command's table update lands as it moves into the result register, so the
// next command sees it. A stalled output holds the result and the input
// register; the input side accepts one more beat only while the input
// register is empty. Reset clears tables, pointer, valid flags and sets
// coord_count to 1. cfg_ready is always high.
`timescale 1ns / 1ps

module alternating_coordinate_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  acs_pkg::acs_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output acs_pkg::acs_out_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acs_pkg::COUNT_BITS-1:0]    cfg_data
);
    import acs_pkg::*;

    acs_in_t               in_data_reg;
    logic                  in_valid_reg;
    acs_out_t              out_data_reg;
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] index_reg [MAX_COORDS];
    acs_dir_t              dir_reg [MAX_COORDS];
    logic [COORD_BITS-1:0] ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic                  advance;
    acs_out_t              step_result;
    acs_upd_t              step_upd;

    // Handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    acs_step u_step (
        .item        (in_data_reg),
        .item_valid  (advance),
        .cur_idx     (index_reg[ptr_reg]),
        .cur_dir     (dir_reg[ptr_reg]),
        .coord_ptr   (ptr_reg),
        .coord_count (count_reg),
        .result      (step_result),
        .upd         (step_upd)
    );

    // Control: valid flags, pointer, config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            count_reg     <= COUNT_BITS'(1);
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step_upd.ptr_wr)
            begin
                ptr_reg <= step_upd.ptr_data;
            end
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Coordinate tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_COORDS; i++)
            begin
                index_reg[i] <= '0;
                dir_reg[i]   <= DIR_RIGHT;
            end
        end
        else if (step_upd.tbl_wr)
        begin
            dir_reg[step_upd.tbl_addr] <= step_upd.dir_data;
            if (step_upd.idx_wr)
            begin
                index_reg[step_upd.tbl_addr] <= step_upd.idx_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

endmodule

[hw/rtl/acs_checker.sv]
// Port-level checks for the alternating coordinate search, bound to the top level.
`timescale 1ns / 1ps

module acs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  acs_pkg::acs_out_t                 out_data
);
    import acs_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // An accepted command reaches the result register when the output side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("result missing two cycles after accept");

    // Result direction is always right, stay or left
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.direction_out == DIR_RIGHT)
                       || (out_data.direction_out == DIR_STAY)
                       || (out_data.direction_out == DIR_LEFT)))
        else $error("illegal direction code");

endmodule

bind alternating_coordinate_search acs_checker u_acs_checker (.*);
